>>> sv/pclpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pclpf_pkg
// Shared types, character codes and the prime-form network for the
// pitch-class line parser.
// ----------------------------------------------------------------------------
package pclpf_pkg;

    localparam int unsigned CharWidth   = 8;
    localparam int unsigned ClassCount  = 12;
    localparam int unsigned InDataWidth  = 8;
    localparam int unsigned OutDataWidth = 32;

    typedef logic [CharWidth-1:0]  char_t;
    typedef logic [ClassCount-1:0] pc_set_t;
    typedef logic [3:0]            residue_t;
    typedef logic [2:0]            dcount_t;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_TOKENS  = 2'd1,
        MODE_COMMENT = 2'd2,
        MODE_DONE    = 2'd3
    } line_mode_t;

    localparam char_t CHAR_NUL   = 8'h00;
    localparam char_t CHAR_TAB   = 8'h09;
    localparam char_t CHAR_LF    = 8'h0A;
    localparam char_t CHAR_CR    = 8'h0D;
    localparam char_t CHAR_SPACE = 8'h20;
    localparam char_t CHAR_HASH  = 8'h23;
    localparam char_t CHAR_STAR  = 8'h2A;
    localparam char_t CHAR_COMMA = 8'h2C;
    localparam char_t CHAR_SEMI  = 8'h3B;
    localparam char_t CHAR_ZERO  = 8'h30;
    localparam char_t CHAR_NINE  = 8'h39;

    localparam dcount_t MaxDigits = 3'd4;
    localparam dcount_t SatDigits = 3'd5;

    // (r * 10) mod 12 for r in 0..11
    function automatic residue_t times10_mod12(input residue_t r);
        residue_t v;
        case (r)
            4'd0, 4'd6:  v = 4'd0;
            4'd1, 4'd7:  v = 4'd10;
            4'd2, 4'd8:  v = 4'd8;
            4'd3, 4'd9:  v = 4'd6;
            4'd4, 4'd10: v = 4'd4;
            4'd5, 4'd11: v = 4'd2;
            default:     v = 4'd0;
        endcase
        return v;
    endfunction

    // (r * 10 + d) mod 12; sum stays below 24, so one compare-subtract
    function automatic residue_t add_digit_mod12(input residue_t r, input logic [3:0] d);
        logic [4:0] sum;
        sum = {1'b0, times10_mod12(r)} + {1'b0, d};
        if (sum >= 5'd12)
            sum = sum - 5'd12;
        return sum[3:0];
    endfunction

    // Candidates are rotations of the set and its mirror with class 0 present.
    // Key = {valid, lowest set bit, value}: larger key = smaller span, then larger value.
    function automatic pc_set_t prime_form_of(input pc_set_t s);
        pc_set_t     m;
        pc_set_t     src;
        pc_set_t     c;
        logic [3:0]  lsb;
        logic [16:0] key [32];
        int          i;
        int          k;
        int          lvl;
        for (k = 0; k < 12; k++)
            m[k] = s[11-k];
        for (i = 0; i < 32; i++)
            key[i] = '0;
        for (i = 0; i < 24; i++)
        begin
            src = (i < 12) ? s : m;
            c   = (src << (i % 12)) | (src >> (12 - (i % 12)));
            lsb = 4'd0;
            for (k = 11; k >= 0; k--)
                if (c[k])
                    lsb = 4'(k);
            key[i] = c[11] ? {1'b1, lsb, c} : 17'd0;
        end
        for (lvl = 0; lvl < 5; lvl++)
            for (i = 0; i < (16 >> lvl); i++)
                key[i] = (key[2*i+1] > key[2*i]) ? key[2*i+1] : key[2*i];
        return key[0][11:0];
    endfunction

endpackage
`default_nettype wire

>>> sv/pitch_class_line_prime_form_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pitch_class_line_prime_form_core
// Parses text lines of note numbers into a pitch-class set and emits the set,
// its prime form and a format error flag at each newline that ends a non-comment line.
// ----------------------------------------------------------------------------
//  channel | dir | width | fields (lsb first)
//  s_*     | in  | 8     | character
//  m_*     | out | 32    | pitch_set[11:0], prime_form[23:12], format_error[24]
//
//  One character per cycle while s_tready is high; parse state updates in the cycle it is accepted.
//  A line result goes through a set register, then the prime-form network
//  into the output register that drives m_tvalid.
//  Reset clears parse state and both valid flags.
//  Stalls: each stage advances when the next is empty or being drained, so
//  s_tready drops only while both result stages are held.
// ----------------------------------------------------------------------------
module pitch_class_line_prime_form_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [pclpf_pkg::InDataWidth-1:0]    s_tdata,  // character[7:0]
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [pclpf_pkg::OutDataWidth-1:0]        m_tdata   // pitch_set, prime_form, format_error
);
    import pclpf_pkg::*;

    line_mode_t mode_reg, mode_next;
    pc_set_t    note_reg, note_next;
    residue_t   res_reg, res_next;
    dcount_t    cnt_reg, cnt_next;
    logic       err_reg, err_next;

    logic       mid_valid_reg;
    pc_set_t    mid_set_reg;
    logic       mid_err_reg;
    logic       out_valid_reg;
    pc_set_t    out_set_reg;
    pc_set_t    out_prime_reg;
    logic       out_err_reg;

    logic       in_fire;
    logic       mid_ready;
    logic       emit;
    pc_set_t    emit_set;
    logic       emit_err;
    char_t      c;
    logic       is_dig;
    logic       is_sep;
    logic       is_nl;

    assign c      = s_tdata;
    assign is_dig = c inside {[CHAR_ZERO:CHAR_NINE]};
    assign is_sep = c inside {CHAR_COMMA, CHAR_SEMI, CHAR_SPACE, CHAR_TAB};
    assign is_nl  = (c == CHAR_LF);

    assign mid_ready = !out_valid_reg || m_tready;
    assign s_tready  = !mid_valid_reg || mid_ready;
    assign in_fire   = s_tvalid && s_tready;

    always_comb
    begin
        mode_next = mode_reg;
        note_next = note_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        err_next  = err_reg;
        emit      = 1'b0;
        emit_set  = note_reg;
        emit_err  = err_reg;
        if (c == CHAR_CR)
        begin
            // carriage return is ignored everywhere
        end
        else if (mode_reg == MODE_COMMENT)
        begin
            if (is_nl)
                mode_next = MODE_START;
        end
        else
        begin
            case (mode_reg)
                MODE_START:
                begin
                    if (c inside {CHAR_STAR, CHAR_HASH})
                        mode_next = MODE_COMMENT;
                    else if (is_sep)
                        mode_next = MODE_TOKENS;
                    else if (is_dig)
                    begin
                        mode_next = MODE_TOKENS;
                        res_next  = add_digit_mod12(res_reg, c[3:0]);
                        cnt_next  = cnt_reg + 3'd1;
                    end
                    else
                    begin
                        err_next  = 1'b1;
                        mode_next = MODE_DONE;
                    end
                end
                MODE_TOKENS:
                begin
                    if (is_dig)
                    begin
                        res_next = add_digit_mod12(res_reg, c[3:0]);
                        if (cnt_reg < SatDigits)
                            cnt_next = cnt_reg + 3'd1;
                    end
                    else
                    begin
                        res_next = '0;
                        cnt_next = '0;
                        if (cnt_reg > MaxDigits)
                        begin
                            err_next  = 1'b1;
                            mode_next = MODE_DONE;
                        end
                        else
                        begin
                            if (cnt_reg != 3'd0)
                                note_next = note_reg | (12'h800 >> res_reg);
                            if (is_nl || (c == CHAR_NUL))
                                mode_next = MODE_DONE;
                            else if (!is_sep)
                            begin
                                err_next  = 1'b1;
                                mode_next = MODE_DONE;
                            end
                        end
                    end
                end
                default:
                begin
                    // rest of line ignored
                end
            endcase
            if (is_nl)
            begin
                emit      = 1'b1;
                emit_set  = note_next;
                emit_err  = err_next;
                mode_next = MODE_START;
                note_next = '0;
                res_next  = '0;
                cnt_next  = '0;
                err_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_START;
            note_reg      <= '0;
            res_reg       <= '0;
            cnt_reg       <= '0;
            err_reg       <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg <= mode_next;
                note_reg <= note_next;
                res_reg  <= res_next;
                cnt_reg  <= cnt_next;
                err_reg  <= err_next;
            end
            if (s_tready)
                mid_valid_reg <= in_fire && emit;
            if (mid_ready)
                out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            mid_set_reg <= emit_set;
            mid_err_reg <= emit_err;
        end
        if (mid_ready && mid_valid_reg)
        begin
            out_set_reg   <= mid_set_reg;
            out_prime_reg <= prime_form_of(mid_set_reg);
            out_err_reg   <= mid_err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_err_reg, out_prime_reg, out_set_reg};

endmodule
`default_nettype wire
